>>> hdl/clnf_pkg.sv
package clnf_pkg;

    // Default digit limit for a request
    localparam int MAX_DIGITS_DEF = 16;

    // A 16-bit magnitude has at most five decimal digits
    localparam int DEC_DIGITS = 5;
    localparam int DEC_IDX_W  = 3;

    // Request modes
    localparam logic [2:0] OP_CHAR = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_SDEC = 3'd2;
    localparam logic [2:0] OP_HEX  = 3'd3;
    localparam logic [2:0] OP_BIN  = 3'd4;

    // Display bus constants
    localparam logic [7:0] CMD_SET_CURSOR = 8'h80;
    localparam logic [7:0] LINE2_OFFSET   = 8'h40;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] ASCII_A        = 8'h41;
    localparam logic [7:0] ASCII_MINUS    = 8'h2D;
    localparam logic [7:0] ASCII_PLUS     = 8'h2B;

    // Reciprocal of ten: floor(m / 10) = (m * DIV10_MUL) >> DIV10_SHIFT for m below 2^18
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Output byte source
    typedef enum logic [1:0] {
        SEL_CMD   = 2'd0,
        SEL_SIGN  = 2'd1,
        SEL_CHAR  = 2'd2,
        SEL_DIGIT = 2'd3
    } out_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     conv_step;
        logic     digit_step;
        out_sel_t sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       count_zero;
        logic       digit_last;
        logic       conv_done;
    } status_t;

endpackage

>>> hdl/clnf_dpath.sv
module clnf_dpath #(
    parameter int MAX_DIGITS = clnf_pkg::MAX_DIGITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  clnf_pkg::cmd_t    cmd,
    output clnf_pkg::status_t status,
    input  logic [2:0]        s_op,
    input  logic [1:0]        s_line,
    input  logic [5:0]        s_column,
    input  logic [15:0]       s_value,
    input  logic [4:0]        s_digit_count,
    output logic [7:0]        m_lcd_byte,
    output logic              m_is_data
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
    localparam int DEC_IDX_W_L = clnf_pkg::DEC_IDX_W;

    logic [2:0]                  op_reg;
    logic [7:0]                  cursor_reg;
    logic                        neg_reg;
    logic [15:0]                 mag_reg, mag_next;
    logic [CNT_W-1:0]            digit_cnt_reg, digit_cnt_next;
    logic [DEC_IDX_W_L-1:0]      conv_cnt_reg, conv_cnt_next;
    logic [3:0]                  dec_buf_reg [clnf_pkg::DEC_DIGITS];

    logic [7:0]       col_m1;
    logic [7:0]       cursor;
    logic [CNT_W-1:0] count_sat;
    logic [31:0]      prod;
    logic [15:0]      quot;
    logic [15:0]      rem_full;
    logic [CNT_W-1:0] digit_idx;
    logic [4:0]       idx_wide;
    logic [15:0]      hex_shift;
    logic [15:0]      bin_shift;
    logic [3:0]       digit;
    logic [7:0]       digit_ascii;
    logic             is_dec;

    // Cursor command for the requested line and column
    always_comb begin
        col_m1 = {2'b00, s_column} - 8'd1;
        cursor = clnf_pkg::CMD_SET_CURSOR | col_m1;
        if (s_line != 2'd1) begin
            cursor = cursor + clnf_pkg::LINE2_OFFSET;
        end
        count_sat = (s_digit_count > 5'(MAX_DIGITS)) ? MAX_CNT : CNT_W'(s_digit_count);
    end

    // Divide the magnitude by ten through its reciprocal
    always_comb begin
        prod     = mag_reg * clnf_pkg::DIV10_MUL;
        quot     = 16'(prod >> clnf_pkg::DIV10_SHIFT);
        rem_full = mag_reg - ((quot << 3) + (quot << 1));
    end

    assign is_dec = (op_reg == clnf_pkg::OP_UDEC) || (op_reg == clnf_pkg::OP_SDEC);

    // Next state of the working registers
    always_comb begin
        mag_next       = mag_reg;
        digit_cnt_next = digit_cnt_reg;
        conv_cnt_next  = conv_cnt_reg;
        if (cmd.load) begin
            mag_next       = (s_op == clnf_pkg::OP_SDEC && s_value[15]) ? (16'd0 - s_value)
                                                                        : s_value;
            digit_cnt_next = count_sat;
            conv_cnt_next  = '0;
        end else if (cmd.conv_step) begin
            mag_next      = quot;
            conv_cnt_next = conv_cnt_reg + 1'b1;
        end else if (cmd.digit_step) begin
            digit_cnt_next = digit_cnt_reg - 1'b1;
        end
    end

    // Hold request fields and step counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_cnt_reg <= '0;
            conv_cnt_reg  <= '0;
        end else begin
            digit_cnt_reg <= digit_cnt_next;
            conv_cnt_reg  <= conv_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        if (cmd.load) begin
            op_reg     <= s_op;
            cursor_reg <= cursor;
            neg_reg    <= (s_op == clnf_pkg::OP_SDEC) && s_value[15];
        end
        if (cmd.conv_step) begin
            dec_buf_reg[conv_cnt_reg] <= rem_full[3:0];
        end
    end

    // Pick the digit at the current position, most significant first
    always_comb begin
        digit_idx = digit_cnt_reg - 1'b1;
        idx_wide  = 5'(digit_idx);
        hex_shift = mag_reg >> {idx_wide, 2'b00};
        bin_shift = mag_reg >> idx_wide;
        unique case (op_reg)
            clnf_pkg::OP_HEX: digit = hex_shift[3:0];
            clnf_pkg::OP_BIN: digit = {3'b000, bin_shift[0]};
            default: begin
                if (idx_wide < 5'(clnf_pkg::DEC_DIGITS)) begin
                    digit = dec_buf_reg[idx_wide[DEC_IDX_W_L-1:0]];
                end else begin
                    digit = 4'd0;
                end
            end
        endcase
        digit_ascii = (digit >= 4'd10) ? (clnf_pkg::ASCII_A + {4'd0, digit} - 8'd10)
                                       : (clnf_pkg::ASCII_ZERO + {4'd0, digit});
    end

    // Drive the output byte from the selected source
    always_comb begin
        unique case (cmd.sel)
            clnf_pkg::SEL_CMD:  m_lcd_byte = cursor_reg;
            clnf_pkg::SEL_SIGN: m_lcd_byte = neg_reg ? clnf_pkg::ASCII_MINUS
                                                     : clnf_pkg::ASCII_PLUS;
            clnf_pkg::SEL_CHAR: m_lcd_byte = mag_reg[7:0];
            default:            m_lcd_byte = digit_ascii;
        endcase
        m_is_data = (cmd.sel != clnf_pkg::SEL_CMD);
    end

    // Report progress to the controller
    always_comb begin
        status.op         = op_reg;
        status.count_zero = (digit_cnt_reg == '0);
        status.digit_last = (digit_cnt_reg == CNT_W'(1));
        status.conv_done  = !is_dec || (conv_cnt_reg == DEC_IDX_W_L'(clnf_pkg::DEC_DIGITS));
    end

endmodule

>>> hdl/clnf_ctrl.sv
module clnf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_last,
    output clnf_pkg::cmd_t    cmd,
    input  clnf_pkg::status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CONV  = 6'b000010,
        ST_CMD   = 6'b000100,
        ST_SIGN  = 6'b001000,
        ST_CHAR  = 6'b010000,
        ST_DIGIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic op_char, op_sdec, op_num;

    assign op_char = (status.op == clnf_pkg::OP_CHAR);
    assign op_sdec = (status.op == clnf_pkg::OP_SDEC);
    assign op_num  = (status.op == clnf_pkg::OP_UDEC) || op_sdec
                  || (status.op == clnf_pkg::OP_HEX) || (status.op == clnf_pkg::OP_BIN);

    // Sequence the bytes of one request
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        m_last         = 1'b0;
        cmd.load       = 1'b0;
        cmd.conv_step  = 1'b0;
        cmd.digit_step = 1'b0;
        cmd.sel        = clnf_pkg::SEL_CMD;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (status.conv_done) begin
                    state_next = ST_CMD;
                end else begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_CMD: begin
                m_valid = 1'b1;
                m_last  = !op_char && !op_sdec && !(op_num && !status.count_zero);
                if (m_ready) begin
                    priority if (op_char) begin
                        state_next = ST_CHAR;
                    end else if (op_sdec) begin
                        state_next = ST_SIGN;
                    end else if (op_num && !status.count_zero) begin
                        state_next = ST_DIGIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SIGN: begin
                m_valid = 1'b1;
                cmd.sel = clnf_pkg::SEL_SIGN;
                m_last  = status.count_zero;
                if (m_ready) begin
                    state_next = status.count_zero ? ST_IDLE : ST_DIGIT;
                end
            end
            ST_CHAR: begin
                m_valid = 1'b1;
                cmd.sel = clnf_pkg::SEL_CHAR;
                m_last  = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIGIT: begin
                m_valid = 1'b1;
                cmd.sel = clnf_pkg::SEL_DIGIT;
                m_last  = status.digit_last;
                if (m_ready) begin
                    cmd.digit_step = 1'b1;
                    if (status.digit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/char_lcd_number_formatter.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_op, s_line, s_column, s_value, s_digit_count
// m_        out        m_valid / m_ready  m_lcd_byte, m_is_data, m_last
//
// One request at a time: the accept cycle loads the request, then the convert state runs
// five divide-by-ten steps for decimal modes through the shared reciprocal multiplier
// before it finishes (other modes finish at once), then one byte is transferred per cycle
// while the output does not stall.
// Output stalls hold the current byte and the sequencer; s_ready is high only when idle.
// Synchronous active-low reset returns the controller to idle with no byte pending.
module char_lcd_number_formatter #(
    parameter int MAX_DIGITS = clnf_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [1:0]  s_line,
    input  logic [5:0]  s_column,
    input  logic [15:0] s_value,
    input  logic [4:0]  s_digit_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_lcd_byte,
    output logic        m_is_data,
    output logic        m_last
);

    clnf_pkg::cmd_t    cmd;
    clnf_pkg::status_t status;

    // Sequencer
    clnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .cmd     (cmd),
        .status  (status)
    );

    // Request registers, digit conversion and byte select
    clnf_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_op          (s_op),
        .s_line        (s_line),
        .s_column      (s_column),
        .s_value       (s_value),
        .s_digit_count (s_digit_count),
        .m_lcd_byte    (m_lcd_byte),
        .m_is_data     (m_is_data)
    );

endmodule
